@@ design/assert_macros.svh @@
// Assertion macros shared by the stopwatch controller RTL.
// Simulation gets concurrent assertions; synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SWCC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SWCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWCC_ASSERT(lbl, clk, rstn, prop, msg)
`define SWCC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ design/swcc_pkg.sv @@
// Types and constants for the stopwatch command controller.
// Used by the channel interfaces and every module of the block.
package swcc_pkg;

  localparam int COUNT_W    = 19;
  localparam int OP_W       = 2;
  localparam int CHAR_W     = 8;
  localparam int EVENT_W    = 3;
  localparam int DIGIT_W    = 4;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(215999);

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_BUTTON = 2'd1;
  localparam logic [OP_W-1:0] OP_CHAR   = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_S_LO = 8'h73;
  localparam logic [CHAR_W-1:0] CHAR_S_UP = 8'h53;
  localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_R_LO = 8'h72;
  localparam logic [CHAR_W-1:0] CHAR_R_UP = 8'h52;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;

  typedef enum logic [EVENT_W-1:0] {
    EV_TICK    = 3'd0,
    EV_STARTED = 3'd1,
    EV_STOPPED = 3'd2,
    EV_RESET   = 3'd3,
    EV_REFUSED = 3'd4,
    EV_WRAP    = 3'd5,
    EV_UNKNOWN = 3'd6,
    EV_CHAR    = 3'd7
  } event_e;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_TOGGLE,
    CMD_CLEAR,
    CMD_SHOW,
    CMD_UNKNOWN
  } cmd_e;

  typedef struct packed {
    logic valid;
    cmd_e cmd;
  } push_req_t;

  typedef struct packed {
    logic                  full;
    logic                  not_empty;
    logic [FIFO_CNT_W-1:0] count;
    cmd_e                  head;
  } fifo_stat_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] h_tens;
    logic [DIGIT_W-1:0] h_ones;
    logic [DIGIT_W-1:0] m_tens;
    logic [DIGIT_W-1:0] m_ones;
    logic [DIGIT_W-1:0] s_tens;
    logic [DIGIT_W-1:0] s_ones;
  } time_t;

endpackage

@@ design/swcc_if.sv @@
// Valid/ready channel interfaces for the stopwatch command controller.
// Depends on swcc_pkg for the payload widths.
interface swcc_in_if;
  import swcc_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CHAR_W-1:0] char_code;
  modport source (output valid, op, char_code, input ready);
  modport sink (input valid, op, char_code, output ready);
endinterface

interface swcc_out_if;
  import swcc_pkg::*;
  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_res;
  logic [CHAR_W-1:0]  out_char;
  logic               last;
  modport source (output valid, event_res, out_char, last, input ready);
  modport sink (input valid, event_res, out_char, last, output ready);
endinterface

@@ design/stopwatch_command_controller_core.sv @@
// Stopwatch command controller: a seconds stopwatch run by ticks, button
// presses and command characters, with a limit register and a result channel.
// Input items are taken every cycle while the two-entry command queue has room.
// The executor behind the queue gives one result per cycle unless the output
// stalls, into a single output register: a tick, toggle, clear or unknown
// character gives one result and a display command nine, one per character of
// HH:MM:SS and newline. The count is kept in binary and as six decimal digits,
// so a display needs no division. There is no clearing pass after reset.
module stopwatch_command_controller_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [swcc_pkg::COUNT_W-1:0] cfg_wdata_i,
  swcc_in_if.sink                      in_i,
  swcc_out_if.source                   out_o
);
  import swcc_pkg::*;
  `include "assert_macros.svh"

  push_req_t  push;
  fifo_stat_t fifo_stat;
  logic       pop;

  swcc_front u_front (
    .in_i        (in_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push)
  );

  swcc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .stat_o (fifo_stat)
  );

  swcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_o       (out_o)
  );

  `SWCC_ASSERT(a_pop_nonempty, clk_i, rst_ni, pop |-> fifo_stat.not_empty, "pop from empty queue")
  `SWCC_ASSERT(a_no_push_full, clk_i, rst_ni, push.valid |-> !fifo_stat.full, "push into full queue")
  `SWCC_ASSERT(a_show_gapless, clk_i, rst_ni, (out_o.valid && !out_o.last) |=> out_o.valid, "gap in display")
  `SWCC_ASSERT(a_cnt_bound, clk_i, rst_ni, fifo_stat.count <= FIFO_CNT_W'(FIFO_DEPTH), "queue overflow")

endmodule

@@ design/swcc_front.sv @@
// Front end: accepts input items and classifies them into commands.
// Depends on swcc_pkg and swcc_in_if.
module swcc_front (
  swcc_in_if.sink          in_i,
  input  swcc_pkg::fifo_stat_t fifo_stat_i,
  output swcc_pkg::push_req_t  push_o
);
  import swcc_pkg::*;

  logic keep;
  cmd_e cmd;

  always_comb begin
    keep = 1'b1;
    cmd  = CMD_UNKNOWN;
    case (in_i.op)
      OP_TICK:   cmd = CMD_TICK;
      OP_BUTTON: cmd = CMD_TOGGLE;
      OP_CHAR: begin
        case (in_i.char_code)
          CHAR_S_LO, CHAR_S_UP: cmd = CMD_TOGGLE;
          CHAR_A_LO, CHAR_A_UP: cmd = CMD_SHOW;
          CHAR_R_LO, CHAR_R_UP: cmd = CMD_CLEAR;
          default:              cmd = CMD_UNKNOWN;
        endcase
      end
      default:   keep = 1'b0;
    endcase
  end

  // An undefined op is accepted and dropped without a result.
  assign in_i.ready   = !fifo_stat_i.full;
  assign push_o.valid = in_i.valid && in_i.ready && keep;
  assign push_o.cmd   = cmd;

endmodule

@@ design/swcc_fifo.sv @@
// Short command queue between the front end and the executor.
// Depends on swcc_pkg.
module swcc_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swcc_pkg::push_req_t  push_i,
  input  logic                 pop_i,
  output swcc_pkg::fifo_stat_t stat_o
);
  import swcc_pkg::*;

  cmd_e                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i.valid && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i.valid && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  assign stat_o.full      = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat_o.not_empty = (count_q != '0);
  assign stat_o.count     = count_q;
  assign stat_o.head      = mem_q[rd_ptr_q];

endmodule

@@ design/swcc_back.sv @@
// Executor: holds the stopwatch state, carries out queued commands and
// drives the registered result channel. Depends on swcc_pkg and swcc_out_if.
module swcc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [swcc_pkg::COUNT_W-1:0] cfg_wdata_i,
  input  swcc_pkg::fifo_stat_t       fifo_stat_i,
  output logic                       pop_o,
  swcc_out_if.source                 out_o
);
  import swcc_pkg::*;

  localparam logic [3:0] SHOW_LAST = 4'd8;
  localparam logic [DIGIT_W-1:0] D_NINE = 4'd9;
  localparam logic [DIGIT_W-1:0] D_FIVE = 4'd5;

  logic [COUNT_W-1:0] limit_q, limit_d;
  logic [COUNT_W-1:0] elapsed_q, elapsed_d;
  logic               running_q, running_d;
  time_t              digits_q, digits_d, digits_inc;
  logic [3:0]         idx_q, idx_d;
  logic               ov_q, ov_d;
  event_e             oev_q, oev_d;
  logic [CHAR_W-1:0]  och_q, och_d;
  logic               olast_q, olast_d;
  logic               out_free, fire;
  logic [COUNT_W:0]   sum;
  logic [DIGIT_W-1:0] digit_sel;
  logic [CHAR_W-1:0]  time_char;

  assign out_free = !ov_q || out_o.ready;
  assign fire     = fifo_stat_i.not_empty && out_free;
  assign sum      = {1'b0, elapsed_q} + 1'b1;

  always_comb begin
    digits_inc = digits_q;
    if (digits_q.s_ones != D_NINE) begin
      digits_inc.s_ones = digits_q.s_ones + 1'b1;
    end else begin
      digits_inc.s_ones = '0;
      if (digits_q.s_tens != D_FIVE) begin
        digits_inc.s_tens = digits_q.s_tens + 1'b1;
      end else begin
        digits_inc.s_tens = '0;
        if (digits_q.m_ones != D_NINE) begin
          digits_inc.m_ones = digits_q.m_ones + 1'b1;
        end else begin
          digits_inc.m_ones = '0;
          if (digits_q.m_tens != D_FIVE) begin
            digits_inc.m_tens = digits_q.m_tens + 1'b1;
          end else begin
            digits_inc.m_tens = '0;
            if (digits_q.h_ones != D_NINE) begin
              digits_inc.h_ones = digits_q.h_ones + 1'b1;
            end else begin
              digits_inc.h_ones = '0;
              digits_inc.h_tens = (digits_q.h_tens != D_NINE) ?
                                  digits_q.h_tens + 1'b1 : '0;
            end
          end
        end
      end
    end
  end

  always_comb begin
    digit_sel = '0;
    time_char = CHAR_ZERO;
    case (idx_q)
      4'd0:    digit_sel = digits_q.h_tens;
      4'd1:    digit_sel = digits_q.h_ones;
      4'd3:    digit_sel = digits_q.m_tens;
      4'd4:    digit_sel = digits_q.m_ones;
      4'd6:    digit_sel = digits_q.s_tens;
      4'd7:    digit_sel = digits_q.s_ones;
      default: digit_sel = '0;
    endcase
    case (idx_q)
      4'd2, 4'd5: time_char = CHAR_COLON;
      SHOW_LAST:  time_char = CHAR_NL;
      default:    time_char = CHAR_ZERO + CHAR_W'(digit_sel);
    endcase
  end

  always_comb begin
    limit_d   = cfg_we_i ? cfg_wdata_i : limit_q;
    elapsed_d = elapsed_q;
    running_d = running_q;
    digits_d  = digits_q;
    idx_d     = idx_q;
    ov_d      = ov_q && !out_o.ready;
    oev_d     = oev_q;
    och_d     = och_q;
    olast_d   = olast_q;
    pop_o     = 1'b0;
    if (fire) begin
      ov_d    = 1'b1;
      och_d   = '0;
      olast_d = 1'b1;
      pop_o   = 1'b1;
      case (fifo_stat_i.head)
        CMD_TICK: begin
          oev_d = EV_TICK;
          if (running_q) begin
            if (sum >= {1'b0, limit_q}) begin
              elapsed_d = '0;
              digits_d  = '0;
              running_d = 1'b0;
              oev_d     = EV_WRAP;
            end else begin
              elapsed_d = sum[COUNT_W-1:0];
              digits_d  = digits_inc;
            end
          end
        end
        CMD_TOGGLE: begin
          running_d = !running_q;
          oev_d     = running_q ? EV_STOPPED : EV_STARTED;
        end
        CMD_CLEAR: begin
          if (running_q) begin
            oev_d = EV_REFUSED;
          end else begin
            elapsed_d = '0;
            digits_d  = '0;
            oev_d     = EV_RESET;
          end
        end
        CMD_SHOW: begin
          oev_d   = EV_CHAR;
          och_d   = time_char;
          olast_d = (idx_q == SHOW_LAST);
          pop_o   = (idx_q == SHOW_LAST);
          idx_d   = (idx_q == SHOW_LAST) ? '0 : idx_q + 1'b1;
        end
        default: begin
          oev_d = EV_UNKNOWN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LIMIT_RESET;
      elapsed_q <= '0;
      running_q <= 1'b0;
      digits_q  <= '0;
      idx_q     <= '0;
      ov_q      <= 1'b0;
    end else begin
      limit_q   <= limit_d;
      elapsed_q <= elapsed_d;
      running_q <= running_d;
      digits_q  <= digits_d;
      idx_q     <= idx_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oev_q   <= oev_d;
    och_q   <= och_d;
    olast_q <= olast_d;
  end

  assign out_o.valid     = ov_q;
  assign out_o.event_res = oev_q;
  assign out_o.out_char  = och_q;
  assign out_o.last      = olast_q;

endmodule
